// ===== hw/rtl/pwd_pkg.sv =====
`default_nettype none

package pwd_pkg;

   localparam int DATA_WIDTH_DEFAULT = 16;
   localparam int ACC_WIDTH_DEFAULT  = 32;
   localparam int CSR_INDEX_WIDTH    = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP          = 3'd0,
      CSR_KI          = 3'd1,
      CSR_KD          = 3'd2,
      CSR_SETPOINT    = 3'd3,
      CSR_LOWER_LIMIT = 3'd4,
      CSR_UPPER_LIMIT = 3'd5,
      CSR_TOLERANCE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic clear;
      logic enabled;
      logic dead;
   } flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pid_with_deadband.sv =====
// PID controller with deadband on signed fixed-point samples (Q1.15 at the default width).
// Each request beat carries one measurement in tdata and a command in tuser: 0 runs one
// control step, 1 clears the integral and the previous error and returns the held output
// (zero while disabled). The block takes one beat per clock cycle unless the response side
// stalls, and answers each with exactly one response beat, through an input register, a
// stage that forms the clipped deadband window, the error and the three gain products, and
// an output stage that updates the saturating integral and sums the terms. Response tuser
// carries the enabled flag (setpoint within the limits, swapped if given in reverse order)
// and the deadband flag. The user must write registers through the csr port only while no
// beat is in flight; the block itself does not enforce this.
`default_nettype none

module pid_with_deadband #(
   parameter int DATA_WIDTH = pwd_pkg::DATA_WIDTH_DEFAULT,
   parameter int ACC_WIDTH  = pwd_pkg::ACC_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [pwd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [DATA_WIDTH-1:0]                csr_wdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // measured
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   // func
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // control
   output logic [((DATA_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   // in_deadband, enabled
   output logic [1:0]                                rsp_tuser
);
   import pwd_pkg::*;

   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;

   logic        [DATA_WIDTH-2:0] kp, ki, kd, tolerance;
   logic signed [DATA_WIDTH-1:0] setpoint, lower_limit, upper_limit;
   logic                         s1_valid, s1_ready;
   flags_type                    s1_flags;
   logic signed [DATA_WIDTH+1:0] s1_prop, s1_intg;
   logic signed [DATA_WIDTH+2:0] s1_deriv;
   logic        [DATA_WIDTH-1:0] control;
   logic                         enabled, in_deadband;

   pwd_csr #(.DATA_WIDTH(DATA_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .kp          (kp),
      .ki          (ki),
      .kd          (kd),
      .setpoint    (setpoint),
      .lower_limit (lower_limit),
      .upper_limit (upper_limit),
      .tolerance   (tolerance)
   );

   pwd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_func     (req_tuser),
      .in_measured (req_tdata[DATA_WIDTH-1:0]),
      .kp          (kp),
      .ki          (ki),
      .kd          (kd),
      .setpoint    (setpoint),
      .lower_limit (lower_limit),
      .upper_limit (upper_limit),
      .tolerance   (tolerance),
      .down_ready  (s1_ready),
      .s1_valid    (s1_valid),
      .s1_flags    (s1_flags),
      .s1_prop     (s1_prop),
      .s1_intg     (s1_intg),
      .s1_deriv    (s1_deriv)
   );

   pwd_accum #(.DATA_WIDTH(DATA_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_accum (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (s1_valid),
      .up_ready    (s1_ready),
      .up_flags    (s1_flags),
      .up_prop     (s1_prop),
      .up_intg     (s1_intg),
      .up_deriv    (s1_deriv),
      .ki          (ki),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_control (control),
      .out_enabled (enabled),
      .out_dead    (in_deadband)
   );

   assign rsp_tdata = TDATA_WIDTH'(control);
   assign rsp_tuser = {in_deadband, enabled};

endmodule

`default_nettype wire

// ===== hw/rtl/pwd_csr.sv =====
`default_nettype none

module pwd_csr #(
   parameter int DATA_WIDTH = pwd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [pwd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [DATA_WIDTH-1:0]                csr_wdata,
   output logic        [DATA_WIDTH-2:0]              kp,
   output logic        [DATA_WIDTH-2:0]              ki,
   output logic        [DATA_WIDTH-2:0]              kd,
   output logic signed [DATA_WIDTH-1:0]              setpoint,
   output logic signed [DATA_WIDTH-1:0]              lower_limit,
   output logic signed [DATA_WIDTH-1:0]              upper_limit,
   output logic        [DATA_WIDTH-2:0]              tolerance
);
   import pwd_pkg::*;

   localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [DATA_WIDTH-2:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [DATA_WIDTH-2:0] tolerance_ff, tolerance_in;
   logic [DATA_WIDTH-1:0] setpoint_ff, setpoint_in;
   logic [DATA_WIDTH-1:0] lower_ff, lower_in, upper_ff, upper_in;

   always_comb begin
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      setpoint_in  = setpoint_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      tolerance_in = tolerance_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KP:          kp_in        = csr_wdata[DATA_WIDTH-2:0];
            CSR_KI:          ki_in        = csr_wdata[DATA_WIDTH-2:0];
            CSR_KD:          kd_in        = csr_wdata[DATA_WIDTH-2:0];
            CSR_SETPOINT:    setpoint_in  = csr_wdata;
            CSR_LOWER_LIMIT: lower_in     = csr_wdata;
            CSR_UPPER_LIMIT: upper_in     = csr_wdata;
            CSR_TOLERANCE:   tolerance_in = csr_wdata[DATA_WIDTH-2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         setpoint_ff  <= '0;
         lower_ff     <= DATA_MIN;
         upper_ff     <= DATA_MAX;
         tolerance_ff <= '0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         setpoint_ff  <= setpoint_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         tolerance_ff <= tolerance_in;
      end
   end

   assign kp          = kp_ff;
   assign ki          = ki_ff;
   assign kd          = kd_ff;
   assign setpoint    = $signed(setpoint_ff);
   assign lower_limit = $signed(lower_ff);
   assign upper_limit = $signed(upper_ff);
   assign tolerance   = tolerance_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pwd_front.sv =====
`default_nettype none

module pwd_front #(
   parameter int DATA_WIDTH = pwd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic                          in_func,
   input  wire logic        [DATA_WIDTH-1:0]  in_measured,
   input  wire logic        [DATA_WIDTH-2:0]  kp,
   input  wire logic        [DATA_WIDTH-2:0]  ki,
   input  wire logic        [DATA_WIDTH-2:0]  kd,
   input  wire logic signed [DATA_WIDTH-1:0]  setpoint,
   input  wire logic signed [DATA_WIDTH-1:0]  lower_limit,
   input  wire logic signed [DATA_WIDTH-1:0]  upper_limit,
   input  wire logic        [DATA_WIDTH-2:0]  tolerance,
   input  wire logic                          down_ready,
   output logic                               s1_valid,
   output pwd_pkg::flags_type                 s1_flags,
   output logic signed [DATA_WIDTH+1:0]       s1_prop,
   output logic signed [DATA_WIDTH+1:0]       s1_intg,
   output logic signed [DATA_WIDTH+2:0]       s1_deriv
);
   import pwd_pkg::*;

   localparam int FRAC = DATA_WIDTH - 1;
   localparam int EW   = DATA_WIDTH + 1;

   logic                    v0_ff, v0_in, func0_ff;
   logic [DATA_WIDTH-1:0]   meas0_ff;
   logic                    v1_ff, v1_in;
   flags_type               flags1_ff, flags1_in;
   logic signed [DATA_WIDTH+1:0] prop1_ff, intg1_ff;
   logic signed [DATA_WIDTH+2:0] deriv1_ff;
   logic signed [EW-1:0]    last_err_ff, last_err_in;

   logic                    s1_room, move01, accept;
   logic signed [EW-1:0]    lo, hi, sp, meas, wlo, whi, err;
   logic signed [EW:0]      diff;
   logic                    en, dead;
   logic signed [2*DATA_WIDTH:0]   prod_p, prod_i;
   logic signed [2*DATA_WIDTH+1:0] prod_d;

   assign s1_room  = !v1_ff || down_ready;
   assign in_ready = !v0_ff || s1_room;
   assign accept   = in_valid && in_ready;
   assign move01   = v0_ff && s1_room;

   always_comb begin
      sp   = EW'(setpoint);
      meas = EW'($signed(meas0_ff));
      if (lower_limit > upper_limit) begin
         lo = EW'(upper_limit);
         hi = EW'(lower_limit);
      end else begin
         lo = EW'(lower_limit);
         hi = EW'(upper_limit);
      end
      en  = (sp >= lo) && (sp <= hi);
      wlo = sp - $signed({2'b00, tolerance});
      whi = sp + $signed({2'b00, tolerance});
      if (wlo < lo) begin
         wlo = lo;
      end
      if (whi > hi) begin
         whi = hi;
      end
      dead = (meas >= wlo) && (meas <= whi);
      err  = dead ? '0 : (sp - meas);
      diff = (EW+1)'(err) - (EW+1)'(last_err_ff);
   end

   assign prod_p = $signed({1'b0, kp}) * err;
   assign prod_i = $signed({1'b0, ki}) * err;
   assign prod_d = $signed({1'b0, kd}) * diff;

   always_comb begin
      v0_in       = accept || (v0_ff && !s1_room);
      v1_in       = move01 || (v1_ff && !down_ready);
      last_err_in = last_err_ff;
      if (move01) begin
         if (func0_ff) begin
            last_err_in = '0;
         end else if (en) begin
            last_err_in = err;
         end
      end
      flags1_in.clear   = func0_ff;
      flags1_in.enabled = en;
      flags1_in.dead    = dead && en && !func0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         last_err_ff <= '0;
      end else begin
         v0_ff       <= v0_in;
         v1_ff       <= v1_in;
         last_err_ff <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func0_ff <= in_func;
         meas0_ff <= in_measured;
      end
      if (move01) begin
         flags1_ff <= flags1_in;
         prop1_ff  <= (DATA_WIDTH+2)'(prod_p >>> FRAC);
         intg1_ff  <= (DATA_WIDTH+2)'(prod_i >>> FRAC);
         deriv1_ff <= (DATA_WIDTH+3)'(prod_d >>> FRAC);
      end
   end

   assign s1_valid = v1_ff;
   assign s1_flags = flags1_ff;
   assign s1_prop  = prop1_ff;
   assign s1_intg  = intg1_ff;
   assign s1_deriv = deriv1_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pwd_accum.sv =====
`default_nettype none

module pwd_accum #(
   parameter int DATA_WIDTH = pwd_pkg::DATA_WIDTH_DEFAULT,
   parameter int ACC_WIDTH  = pwd_pkg::ACC_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          up_valid,
   output logic                               up_ready,
   input  wire pwd_pkg::flags_type            up_flags,
   input  wire logic signed [DATA_WIDTH+1:0]  up_prop,
   input  wire logic signed [DATA_WIDTH+1:0]  up_intg,
   input  wire logic signed [DATA_WIDTH+2:0]  up_deriv,
   input  wire logic        [DATA_WIDTH-2:0]  ki,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic        [DATA_WIDTH-1:0]       out_control,
   output logic                               out_enabled,
   output logic                               out_dead
);
   import pwd_pkg::*;

   localparam int SW = ((ACC_WIDTH > DATA_WIDTH + 2) ? ACC_WIDTH : DATA_WIDTH + 2) + 1;
   localparam int CW = ((ACC_WIDTH > DATA_WIDTH + 3) ? ACC_WIDTH : DATA_WIDTH + 3) + 2;
   localparam logic signed [SW-1:0] ACC_HI =
      {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;
   localparam logic signed [CW-1:0] OUT_HI =
      {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [CW-1:0] OUT_LO = ~OUT_HI;

   logic signed [ACC_WIDTH-1:0] integral_ff, integral_in, intg_sat;
   logic [DATA_WIDTH-1:0]       held_ff, held_in;
   logic                        v2_ff, v2_in;
   logic [DATA_WIDTH-1:0]       control_ff, control_in;
   logic                        enabled_ff, dead_ff;
   logic signed [SW-1:0]        intg_sum;
   logic signed [CW-1:0]        ctl_sum;
   logic [DATA_WIDTH-1:0]       ctl_sat;
   logic                        fire;

   assign up_ready = !v2_ff || out_ready;
   assign fire     = up_valid && up_ready;

   always_comb begin
      intg_sum = SW'(integral_ff) + SW'(up_intg);
      if (ki == '0) begin
         intg_sat = '0;
      end else if (intg_sum > ACC_HI) begin
         intg_sat = ACC_WIDTH'(ACC_HI);
      end else if (intg_sum < ACC_LO) begin
         intg_sat = ACC_WIDTH'(ACC_LO);
      end else begin
         intg_sat = ACC_WIDTH'(intg_sum);
      end
      ctl_sum = CW'(up_prop) + CW'(intg_sat) + CW'(up_deriv);
      if (ctl_sum > OUT_HI) begin
         ctl_sat = DATA_WIDTH'(OUT_HI);
      end else if (ctl_sum < OUT_LO) begin
         ctl_sat = DATA_WIDTH'(OUT_LO);
      end else begin
         ctl_sat = DATA_WIDTH'(ctl_sum);
      end
   end

   always_comb begin
      v2_in       = fire || (v2_ff && !out_ready);
      integral_in = integral_ff;
      held_in     = held_ff;
      if (!up_flags.enabled) begin
         control_in = '0;
      end else if (up_flags.clear) begin
         control_in = held_ff;
      end else begin
         control_in = ctl_sat;
      end
      if (fire) begin
         if (up_flags.clear) begin
            integral_in = '0;
         end else if (up_flags.enabled) begin
            integral_in = intg_sat;
            held_in     = ctl_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff       <= 1'b0;
         integral_ff <= '0;
         held_ff     <= '0;
      end else begin
         v2_ff       <= v2_in;
         integral_ff <= integral_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         control_ff <= control_in;
         enabled_ff <= up_flags.enabled;
         dead_ff    <= up_flags.dead;
      end
   end

   assign out_valid   = v2_ff;
   assign out_control = control_ff;
   assign out_enabled = enabled_ff;
   assign out_dead    = dead_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pwd_checker.sv =====
`default_nettype none

module pwd_checker #(
   parameter int DATA_WIDTH = pwd_pkg::DATA_WIDTH_DEFAULT
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [((DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   input wire logic [1:0]                         rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Response beat shown straight after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled response beat changed.");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("Disabled response carries a drive value or deadband flag.");

   a_dead_zero_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("Deadband flag set while disabled.");

endmodule

bind pid_with_deadband pwd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pwd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
